/* design/ppcd_pkg.sv */
// Shared types and constants for the peak-preserving column decimator.
// Used by every module of the block; no dependencies of its own.
package ppcd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int IO_LANES       = 4;
  localparam int DEF_LANES      = 4;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [15:0] STEP_RESET  = 16'd32768;
  localparam logic [15:0] SWEEP_RESET = 16'd5000;
  localparam logic [2:0]  LANES_RESET = 3'd4;

  localparam logic signed [SAMPLE_BITS-1:0] RANGE_HIGH_RESET = -16'sd9999;
  localparam logic signed [SAMPLE_BITS-1:0] RANGE_LOW_RESET  = 16'sd9999;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  typedef enum logic [1:0] {
    CFG_COLUMN_STEP  = 2'd0,
    CFG_SWEEP_LENGTH = 2'd1,
    CFG_ACTIVE_LANES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic step;
    logic adv;
  } lane_ctl_t;

  typedef struct packed {
    logic [15:0]               column;
    smp_t [IO_LANES-1:0]       pick;
    smp_t [IO_LANES-1:0]       center;
  } result_t;

endpackage

/* design/ppcd_column.sv */
// Column position tracker: sample counter, fixed-point column position and
// advance detection. Depends on ppcd_pkg.
module ppcd_column import ppcd_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        start_req,
  input  logic        step_write,
  input  logic [15:0] column_step,
  input  logic [15:0] sweep_length,
  output lane_ctl_t   ctl,
  output logic        emit,
  output logic [15:0] column,
  output logic        busy
);

  localparam int POS_BITS = (COUNT_BITS + 16 > 32) ? COUNT_BITS + 16 : 32;
  localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] count;
  logic [POS_BITS-1:0]   pos;
  logic [15:0]           last_column;
  logic                  dirty;

  logic [POS_BITS-1:0]   prod;
  logic [15:0]           col;
  logic                  in_range;
  logic                  adv;
  logic                  saturated;

  assign prod      = POS_BITS'(count) * POS_BITS'(column_step);
  assign col       = pos[31:16];
  assign in_range  = CMP_BITS'(count) < CMP_BITS'(sweep_length);
  assign adv       = !start_req && in_range && (col > last_column);
  assign saturated = (count == {COUNT_BITS{1'b1}});

  assign ctl.start = accept && start_req;
  assign ctl.step  = accept && !start_req && in_range;
  assign ctl.adv   = adv;
  assign emit      = start_req || adv;
  assign column    = start_req ? 16'd0 : col;
  assign busy      = dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      pos         <= '0;
      last_column <= '0;
      dirty       <= 1'b0;
    end else begin
      dirty <= step_write;
      if (dirty) begin
        pos <= prod;
      end else if (ctl.start) begin
        count       <= COUNT_BITS'(1);
        pos         <= POS_BITS'(column_step);
        last_column <= '0;
      end else if (ctl.step) begin
        if (!saturated) begin
          count <= count + COUNT_BITS'(1);
          pos   <= pos + POS_BITS'(column_step);
        end
        if (adv) begin
          last_column <= col;
        end
      end
    end
  end

endmodule

/* design/ppcd_lane.sv */
// One signal lane: column high/low, last pick and emitted range, with the
// farther-extreme pick and range midpoint. Depends on ppcd_pkg.
module ppcd_lane import ppcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lane_ctl_t ctl,
  input  logic      enable,
  input  smp_t      sample,
  output smp_t      pick,
  output smp_t      center
);

  smp_t col_high;
  smp_t col_low;
  smp_t last_pick;
  smp_t range_high;
  smp_t range_low;

  smp_t                    high_w;
  smp_t                    low_w;
  logic signed [16:0]      up;
  logic signed [16:0]      dn;
  smp_t                    p;
  smp_t                    range_high_next;
  smp_t                    range_low_next;
  logic signed [16:0]      sum;
  logic signed [16:0]      half;

  always_comb begin
    high_w = col_high;
    low_w  = col_low;
    priority if (sample > col_high) begin
      high_w = sample;
    end else if (sample < col_low) begin
      low_w = sample;
    end
    up = 17'(high_w) - 17'(last_pick);
    dn = 17'(last_pick) - 17'(low_w);
    p  = (up > dn) ? high_w : low_w;
    if (ctl.start) begin
      range_high_next = sample;
      range_low_next  = sample;
    end else begin
      range_high_next = (p > range_high) ? p : range_high;
      range_low_next  = (p < range_low) ? p : range_low;
    end
    sum  = 17'(range_high_next) + 17'(range_low_next);
    half = (sum + 17'(sum[16])) >>> 1;
  end

  assign pick   = !enable ? '0 : (ctl.start ? sample : p);
  assign center = enable ? half[15:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_high   <= '0;
      col_low    <= '0;
      last_pick  <= '0;
      range_high <= RANGE_HIGH_RESET;
      range_low  <= RANGE_LOW_RESET;
    end else if (enable) begin
      if (ctl.start) begin
        col_high   <= sample;
        col_low    <= sample;
        last_pick  <= sample;
        range_high <= sample;
        range_low  <= sample;
      end else if (ctl.step) begin
        if (ctl.adv) begin
          col_high   <= p;
          col_low    <= p;
          last_pick  <= p;
          range_high <= range_high_next;
          range_low  <= range_low_next;
        end else begin
          col_high <= high_w;
          col_low  <= low_w;
        end
      end
    end
  end

endmodule

/* design/ppcd_merge.sv */
// Merging stage: gathers the column and the lane picks into one result and
// holds it in a two-entry output buffer. Depends on ppcd_pkg.
module ppcd_merge import ppcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [15:0]         column,
  input  smp_t [IO_LANES-1:0] pick,
  input  smp_t [IO_LANES-1:0] center,
  output logic                full,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result
);

  result_t main_q;
  result_t skid_q;
  result_t incoming;
  logic    main_v;
  logic    skid_v;
  logic    take;

  assign incoming.column = column;
  assign incoming.pick   = pick;
  assign incoming.center = center;

  assign take         = main_v && !result_stall;
  assign full         = skid_v;
  assign result_valid = main_v;
  assign result       = main_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (take || !main_v) begin
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !main_v) begin
      if (skid_v) begin
        main_q <= skid_q;
      end else if (push) begin
        main_q <= incoming;
      end
    end else if (push) begin
      skid_q <= incoming;
    end
  end

endmodule

/* design/peak_preserving_column_decimator_core.sv */
// Peak-preserving column decimator top level: configuration registers,
// column tracker, lanes and merging stage. Depends on ppcd_pkg.
//
// Takes one sample vector per clock cycle while sample_stall is low; each
// result is registered in the output buffer before it reaches the output.
// All lanes work in parallel, and the column position is kept by an
// accumulator that adds column_step once per request. A two-entry output
// buffer lets requests keep flowing while a result waits; sample_stall
// rises when both entries are held, and after a write to column_step, while
// the column position is recomputed with one multiply.
module peak_preserving_column_decimator_core import ppcd_pkg::*; #(
  parameter int LANES      = DEF_LANES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic        start_req,
  input  smp_t        sample_0,
  input  smp_t        sample_1,
  input  smp_t        sample_2,
  input  smp_t        sample_3,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] column_index,
  output smp_t        pick_0,
  output smp_t        pick_1,
  output smp_t        pick_2,
  output smp_t        pick_3,
  output smp_t        center_0,
  output smp_t        center_1,
  output smp_t        center_2,
  output smp_t        center_3
);

  localparam int LANE_CNT = (LANES < IO_LANES) ? LANES : IO_LANES;

  logic [15:0] column_step;
  logic [15:0] sweep_length;
  logic [2:0]  active_lanes;
  logic        step_write;

  logic                accept;
  logic                busy;
  logic                full;
  logic                emit;
  logic [15:0]         column;
  lane_ctl_t           ctl;
  logic [2:0]          lanes_lo;
  logic [2:0]          lanes_in_use;
  smp_t [IO_LANES-1:0] samples;
  smp_t [IO_LANES-1:0] picks;
  smp_t [IO_LANES-1:0] centers;
  result_t             result;

  assign step_write = cfg_write && (cfg_index == CFG_COLUMN_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_step  <= STEP_RESET;
      sweep_length <= SWEEP_RESET;
      active_lanes <= LANES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COLUMN_STEP:  column_step  <= cfg_data;
        CFG_SWEEP_LENGTH: sweep_length <= cfg_data;
        CFG_ACTIVE_LANES: active_lanes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign lanes_lo     = (active_lanes == 3'd0) ? 3'd1 : active_lanes;
  assign lanes_in_use = (lanes_lo > 3'(LANE_CNT)) ? 3'(LANE_CNT) : lanes_lo;

  assign sample_stall = busy || full;
  assign accept       = sample_valid && !sample_stall;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;

  ppcd_column #(
    .COUNT_BITS(COUNT_BITS)
  ) u_column (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .start_req   (start_req),
    .step_write  (step_write),
    .column_step (column_step),
    .sweep_length(sweep_length),
    .ctl         (ctl),
    .emit        (emit),
    .column      (column),
    .busy        (busy)
  );

  for (genvar i = 0; i < IO_LANES; i++) begin : g_lane
    if (i < LANE_CNT) begin : g_used
      ppcd_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .enable(3'(i) < lanes_in_use),
        .sample(samples[i]),
        .pick  (picks[i]),
        .center(centers[i])
      );
    end else begin : g_unused
      assign picks[i]   = '0;
      assign centers[i] = '0;
    end
  end

  ppcd_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && emit && (ctl.start || ctl.step)),
    .column      (column),
    .pick        (picks),
    .center      (centers),
    .full        (full),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  assign column_index = result.column;
  assign pick_0       = result.pick[0];
  assign pick_1       = result.pick[1];
  assign pick_2       = result.pick[2];
  assign pick_3       = result.pick[3];
  assign center_0     = result.center[0];
  assign center_1     = result.center[1];
  assign center_2     = result.center[2];
  assign center_3     = result.center[3];

endmodule

/* tb/tb.sv */
// Self-checking bench for peak_preserving_column_decimator_core: directed and random
// sample vectors under random gaps and stalls, checked against a cycle-free column model.
// Depends on ppcd_pkg and the decimator RTL.
module tb;
  import ppcd_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic        start_req = 1'b0;
  smp_t        sample_0 = '0;
  smp_t        sample_1 = '0;
  smp_t        sample_2 = '0;
  smp_t        sample_3 = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [15:0] column_index;
  smp_t        pick_0, pick_1, pick_2, pick_3;
  smp_t        center_0, center_1, center_2, center_3;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;

  logic [15:0] step_q = STEP_RESET;
  logic [15:0] sweep_q = SWEEP_RESET;
  logic [2:0]  lanes_q = LANES_RESET;
  logic [15:0] pos_count = '0;
  logic [15:0] shown_col = '0;
  int col_hi[4] = '{4{0}};
  int col_lo[4] = '{4{0}};
  int shown_pick[4] = '{4{0}};
  int span_hi[4] = '{4{int'(RANGE_HIGH_RESET)}};
  int span_lo[4] = '{4{int'(RANGE_LOW_RESET)}};
  result_t pending_columns[$];

  peak_preserving_column_decimator_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .start_req(start_req),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
    .result_valid(result_valid), .result_stall(result_stall), .column_index(column_index),
    .pick_0(pick_0), .pick_1(pick_1), .pick_2(pick_2), .pick_3(pick_3),
    .center_0(center_0), .center_1(center_1), .center_2(center_2), .center_3(center_3)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("[peak_preserving_column_decimator_core] ERROR");
      $finish;
    end
  end

  function automatic int pause_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int lanes_used();
    if (lanes_q == 3'd0) return 1;
    if (lanes_q > 3'd4) return 4;
    return int'(lanes_q);
  endfunction

  task automatic apply_reg(input logic [1:0] idx, input logic [15:0] val);
    unique case (idx)
      CFG_COLUMN_STEP:  step_q = val;
      CFG_SWEEP_LENGTH: sweep_q = val;
      CFG_ACTIVE_LANES: lanes_q = val[2:0];
      default: ;
    endcase
  endtask

  task automatic decimate_sample(input logic st, input smp_t v[4]);
    int n;
    int up, dn, p;
    logic [31:0] prod;
    logic [15:0] col;
    result_t r;
    n = lanes_used();
    if (st) begin
      for (int s = 0; s < n; s++) begin
        col_hi[s] = v[s];
        col_lo[s] = v[s];
        shown_pick[s] = v[s];
        span_hi[s] = v[s];
        span_lo[s] = v[s];
      end
      pos_count = 16'd1;
      shown_col = '0;
    end else begin
      if (pos_count >= sweep_q) return;
      prod = 32'(pos_count) * 32'(step_q);
      col = prod[31:16];
      for (int s = 0; s < n; s++) begin
        if (v[s] > col_hi[s]) col_hi[s] = v[s];
        else if (v[s] < col_lo[s]) col_lo[s] = v[s];
      end
      if (pos_count != 16'hFFFF) pos_count++;
      if (col <= shown_col) return;
      shown_col = col;
      for (int s = 0; s < n; s++) begin
        up = col_hi[s] - shown_pick[s];
        dn = shown_pick[s] - col_lo[s];
        p = (up > dn) ? col_hi[s] : col_lo[s];
        shown_pick[s] = p;
        col_hi[s] = p;
        col_lo[s] = p;
        if (p > span_hi[s]) span_hi[s] = p;
        if (p < span_lo[s]) span_lo[s] = p;
      end
    end
    r = '0;
    r.column = shown_col;
    for (int s = 0; s < n; s++) begin
      r.pick[s] = 16'(shown_pick[s]);
      r.center[s] = 16'((span_hi[s] + span_lo[s]) / 2);
    end
    pending_columns.push_back(r);
  endtask

  task automatic flag(input string what, input int want, input int got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_column();
    result_t want;
    smp_t got_pick[4];
    smp_t got_center[4];
    got_pick = '{pick_0, pick_1, pick_2, pick_3};
    got_center = '{center_0, center_1, center_2, center_3};
    if (pending_columns.size() == 0) begin
      errors++;
      if (errors <= 10) $display("mismatch: result for column %0d with none pending", column_index);
      return;
    end
    want = pending_columns.pop_front();
    if (want.column !== column_index)
      flag("column_index", int'(want.column), int'(column_index));
    for (int s = 0; s < 4; s++) begin
      if (want.pick[s] !== got_pick[s])
        flag($sformatf("pick_%0d", s), int'($signed(want.pick[s])), int'(got_pick[s]));
      if (want.center[s] !== got_center[s])
        flag($sformatf("center_%0d", s), int'($signed(want.center[s])), int'(got_center[s]));
    end
  endtask

  always @(posedge clk) begin : monitor
    smp_t lane_in[4];
    if (!rst) begin
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (sample_valid && !sample_stall) begin
        lane_in = '{sample_0, sample_1, sample_2, sample_3};
        decimate_sample(start_req, lane_in);
      end
      if (result_valid && !result_stall) check_column();
    end
  end

  always @(negedge clk) begin : receiver
    int n;
    if (hold_left > 0) begin
      hold_left--;
      result_stall = 1'b1;
    end else begin
      n = pause_len(stall_pct);
      result_stall = (n > 0);
      hold_left = (n > 0) ? n - 1 : 0;
    end
  end

  task automatic send_vec(input logic st, input smp_t a, input smp_t b, input smp_t c,
                          input smp_t d);
    int gap;
    gap = pause_len(idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start_req = st;
    sample_0 = a;
    sample_1 = b;
    sample_2 = c;
    sample_3 = d;
    sample_valid = 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    sample_valid = 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic smp_t rand_sample();
    unique case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3, 4: return smp_t'($urandom);
      5: return smp_t'($urandom_range(8) - 4);
      default: return smp_t'($urandom_range(600) - 300);
    endcase
  endfunction

  task automatic send_rand(input logic st);
    send_vec(st, rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  // range still at its reset bounds: no start yet
  task automatic test_before_start();
    idle_pct = 30;
    stall_pct = 30;
    send_vec(0, 16'sh7FFF, -16'sd200, 16'sd12000, 16'sd3);
    send_vec(0, 16'sh8000, 16'sd150, -16'sd11000, -16'sd3);
    send_vec(0, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
    send_vec(0, -16'sd20000, 16'sd20000, 16'sd9999, -16'sd9999);
    send_vec(0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_tie_and_extremes();
    send_vec(1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_vec(0, 16'sd5, 16'sd100, -16'sd7, 16'sh7FFF);
    send_vec(0, -16'sd5, -16'sd100, 16'sd7, 16'sh8000);
    send_vec(0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_vec(0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_sweep_end();
    settle();
    write_reg(CFG_COLUMN_STEP, 16'd49151);
    write_reg(CFG_SWEEP_LENGTH, 16'd2);
    send_vec(1, 16'sd10, -16'sd10, 16'sd20, -16'sd20);
    send_vec(0, 16'sd30, -16'sd30, 16'sd40, -16'sd40);
    send_vec(0, 16'sd50, -16'sd50, 16'sd60, -16'sd60);
    send_vec(1, -16'sd1, 16'sd1, -16'sd2, 16'sd2);
  endtask

  task automatic test_lane_count();
    settle();
    write_reg(CFG_COLUMN_STEP, 16'd32768);
    write_reg(CFG_SWEEP_LENGTH, 16'd5000);
    write_reg(CFG_ACTIVE_LANES, 16'd0);
    send_vec(1, 16'sd100, 16'sd200, 16'sd300, 16'sd400);
    send_vec(0, 16'sd900, -16'sd900, 16'sd900, -16'sd900);
    send_vec(0, -16'sd50, 16'sd50, -16'sd50, 16'sd50);
    settle();
    write_reg(CFG_ACTIVE_LANES, 16'd7);
    send_vec(1, -16'sd100, -16'sd200, -16'sd300, -16'sd400);
    send_vec(0, 16'sd700, 16'sd800, 16'sd900, 16'sd1000);
    send_vec(0, -16'sd700, -16'sd800, -16'sd900, -16'sd1000);
  endtask

  task automatic test_step_zero();
    settle();
    write_reg(CFG_COLUMN_STEP, 16'd0);
    write_reg(CFG_ACTIVE_LANES, 16'd3);
    send_vec(1, 16'sd5, 16'sd6, 16'sd7, 16'sd8);
    send_vec(0, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1);
    send_vec(0, 16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1);
  endtask

  task automatic test_random();
    int counted;
    int full;
    int body;
    logic [15:0] step_v;
    logic [15:0] sweep_v;
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      idle_pct = (ph % 4 == 0) ? 0 : ((ph % 2 == 1) ? 25 : 60);
      stall_pct = (ph % 4 == 0) ? 0 : ((ph % 3 == 0) ? 60 : 25);
      case (ph)
        0: begin step_v = 16'd49151; sweep_v = 16'd2; end
        1: begin step_v = 16'd1; sweep_v = 16'd65535; end
        2: begin step_v = 16'd49151; sweep_v = 16'd65535; end
        default: begin
          step_v = ($urandom_range(4) == 0) ? 16'($urandom_range(49151, 1))
                                            : 16'($urandom_range(40000, 4000));
          sweep_v = 16'($urandom_range(120, 2));
        end
      endcase
      write_reg(CFG_COLUMN_STEP, step_v);
      write_reg(CFG_SWEEP_LENGTH, sweep_v);
      write_reg(CFG_ACTIVE_LANES, 16'($urandom_range(7)));
      counted = 0;
      while (counted < 115) begin
        if ($urandom_range(99) < 8) begin
          repeat ($urandom_range(3, 1)) send_rand(0);
        end else begin
          full = (int'(sweep_v) - 1 > 150) ? 150 : int'(sweep_v) - 1;
          send_rand(1);
          counted++;
          if ($urandom_range(99) < 75) body = full + $urandom_range(3);
          else body = $urandom_range(full);
          for (int i = 0; i < body; i++) send_rand(0);
          counted += (body < full) ? body : full;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_before_start();
    test_tie_and_extremes();
    test_sweep_end();
    test_lane_count();
    test_step_zero();
    test_random();
    settle();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending_columns.size() == 0)
      $display("[peak_preserving_column_decimator_core] OK");
    else
      $display("[peak_preserving_column_decimator_core] ERROR");
    $finish;
  end

endmodule
